// ===== rtl/alpha_over_blend_assert.svh =====
// Assertion macros for the alpha over blend block.
// A clocked check with a reset that disables it, and a clocked check that also
// holds while reset is asserted.
`ifndef ALPHA_OVER_BLEND_ASSERT_SVH
`define ALPHA_OVER_BLEND_ASSERT_SVH
`ifndef SYNTHESIS
`define OBL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define OBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OBL_ASSERT(lbl, clk, rst_n, prop, msg)
`define OBL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/obl_pkg.sv =====
package obl_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned DvsW     = 16;
  localparam int unsigned NumW     = 24;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned NumCells = 8;

  // Lane assignment of the result. The colour lanes run through the divider
  // row, the alpha lane is finished before it and only travels along.
  localparam int unsigned LaneRed   = 0;
  localparam int unsigned LaneGreen = 1;
  localparam int unsigned LaneBlue  = 2;
  localparam int unsigned LaneAlpha = 3;
  localparam int unsigned NumColour = 3;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  typedef struct packed {
    logic [ChanW-1:0] back_red;
    logic [ChanW-1:0] back_green;
    logic [ChanW-1:0] back_blue;
    logic [ChanW-1:0] back_alpha;
    logic [ChanW-1:0] front_red;
    logic [ChanW-1:0] front_green;
    logic [ChanW-1:0] front_blue;
    logic [ChanW-1:0] front_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } pix_out_t;

  // Partial state of the three colour divisions as it travels along the cell
  // row, together with the finished alpha.
  typedef struct packed {
    logic [NumColour-1:0][NumW-1:0] rem;
    logic [DvsW-1:0]                dvs;
    logic [NumLanes-1:0][ChanW-1:0] quo;
  } div_stage_t;

endpackage

// ===== rtl/obl_pix_if.sv =====
interface obl_pix_in_if;
  import obl_pkg::*;

  logic    valid;
  logic    ready;
  pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface obl_pix_out_if;
  import obl_pkg::*;

  logic     valid;
  logic     ready;
  pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/alpha_over_blend.sv =====
// Channel  Direction  Payload                                   Transfer when
// pix_i    in         back RGBA and front RGBA, 8 bits each     pix_i.valid && pix_i.ready
// pix_o    out        blended RGBA, 8 bits each                 pix_o.valid && pix_o.ready
//
// One pixel is taken every clock unless an output stall has backed up the stages;
// each pixel passes through two weighting stages and then the eight divider cells.
// The cell row produces one quotient bit per cell.
// Reset clears only the valid flags of the stages; payload registers hold junk.
// Every stage has its own valid flag and fills gaps, so a stall at the output
// only holds back pixels once the stages in front of it are all occupied.
`include "alpha_over_blend_assert.svh"

module alpha_over_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  obl_pix_in_if.sink        pix_i,
  obl_pix_out_if.source     pix_o
);
  import obl_pkg::*;

  // Index 0 is the output of the weighting stages, index NumCells the output
  // of the last divider cell.
  logic       cell_valid [NumCells+1];
  logic       cell_ready [NumCells+1];
  div_stage_t chain      [NumCells+1];

  // Terms for the checks at the end of the module.
  logic       rem_in_range;
  logic       row_full;

  // The weighting stages form the two weights, their sum D and the three
  // colour numerators. They hand over divisor D, or one for a transparent
  // foreground, together with the finished alpha, which is D divided by 255
  // with a shift and two additions.
  obl_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .data_i  (pix_i.data),
    .valid_o (cell_valid[0]),
    .ready_i (cell_ready[0]),
    .stage_o (chain[0])
  );

  // Each cell settles one quotient bit, most significant first. All quotients
  // stay below 256 because every numerator is at most 255 times its divisor.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    obl_div_cell #(
      .BitIdx (NumCells - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[k]),
      .ready_o (cell_ready[k]),
      .stage_i (chain[k]),
      .valid_o (cell_valid[k+1]),
      .ready_i (cell_ready[k+1]),
      .stage_o (chain[k+1])
    );
  end

  assign cell_ready[NumCells] = pix_o.ready;
  assign pix_o.valid          = cell_valid[NumCells];

  assign pix_o.data.out_red   = chain[NumCells].quo[LaneRed];
  assign pix_o.data.out_green = chain[NumCells].quo[LaneGreen];
  assign pix_o.data.out_blue  = chain[NumCells].quo[LaneBlue];
  assign pix_o.data.out_alpha = chain[NumCells].quo[LaneAlpha];

  assign rem_in_range = (chain[NumCells].rem[LaneRed]   < NumW'(chain[NumCells].dvs))
                     && (chain[NumCells].rem[LaneGreen] < NumW'(chain[NumCells].dvs))
                     && (chain[NumCells].rem[LaneBlue]  < NumW'(chain[NumCells].dvs));

  assign row_full = cell_valid[1] && cell_valid[2] && cell_valid[3] && cell_valid[4]
                 && cell_valid[5] && cell_valid[6] && cell_valid[7] && cell_valid[8];

  // Every division must have finished with a remainder below its divisor.
  `OBL_ASSERT(a_rem_below_dvs, clk_i, rst_ni, pix_o.valid |-> rem_in_range, "divider row left a remainder not below its divisor")
  // A stalled output with a full row must hold back the weighting stages.
  `OBL_ASSERT(a_full_row_stall, clk_i, rst_ni, (row_full && !pix_o.ready) |-> !cell_ready[0], "cell row took a transfer while full and stalled")
  // No result may be offered while reset is held.
  `OBL_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !pix_o.valid, "result offered during reset")

endmodule

// ===== rtl/obl_prep.sv =====
module obl_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  obl_pkg::pix_in_t     data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output obl_pkg::div_stage_t  stage_o
);
  import obl_pkg::*;

  typedef struct packed {
    logic [DvsW-1:0]                 bw;
    logic [DvsW-1:0]                 fw;
    logic [DvsW-1:0]                 dsum;
    logic                            fa_zero;
    logic [NumColour-1:0][ChanW-1:0] back;
    logic [NumColour-1:0][ChanW-1:0] front;
  } weight_t;

  logic       w_valid_q, s_valid_q;
  logic       w_ready, s_ready;
  weight_t    w_d, w_q;
  div_stage_t s_d, s_q;

  assign s_ready = !s_valid_q || ready_i;
  assign w_ready = !w_valid_q || s_ready;
  assign ready_o = w_ready;

  // First stage: the two alpha weights and their sum.
  always_comb begin
    w_d.bw      = DvsW'(data_i.back_alpha) * DvsW'(ChanMax - data_i.front_alpha);
    w_d.fw      = DvsW'(ChanMax) * DvsW'(data_i.front_alpha);
    w_d.dsum    = DvsW'({1'b0, w_d.bw} + {1'b0, w_d.fw});
    w_d.fa_zero = (data_i.front_alpha == '0);
    w_d.back[LaneRed]    = data_i.back_red;
    w_d.back[LaneGreen]  = data_i.back_green;
    w_d.back[LaneBlue]   = data_i.back_blue;
    w_d.front[LaneRed]   = data_i.front_red;
    w_d.front[LaneGreen] = data_i.front_green;
    w_d.front[LaneBlue]  = data_i.front_blue;
  end

  // Second stage: weighted numerators. A transparent foreground divides the
  // background channel by one, so it passes unchanged. The alpha is D over
  // 255; as D never exceeds 65025, that equals (D + (D >> 8) + 1) >> 8.
  always_comb begin
    logic [DvsW:0] alpha_sum;
    for (int l = 0; l < NumColour; l++) begin
      if (w_q.fa_zero) begin
        s_d.rem[l] = NumW'(w_q.back[l]);
      end else begin
        s_d.rem[l] = NumW'(NumW'(w_q.back[l]) * NumW'(w_q.bw))
                   + NumW'(NumW'(w_q.front[l]) * NumW'(w_q.fw));
      end
    end
    s_d.dvs = w_q.fa_zero ? DvsW'(1) : w_q.dsum;
    alpha_sum = {1'b0, w_q.dsum} + (DvsW+1)'(w_q.dsum >> ChanW) + (DvsW+1)'(1);
    s_d.quo = '0;
    s_d.quo[LaneAlpha] = alpha_sum[ChanW +: ChanW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      if (w_ready) w_valid_q <= valid_i;
      if (s_ready) s_valid_q <= w_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_ready && valid_i) w_q <= w_d;
    if (s_ready && w_valid_q) s_q <= s_d;
  end

  assign valid_o = s_valid_q;
  assign stage_o = s_q;

endmodule

// ===== rtl/obl_div_cell.sv =====
module obl_div_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  obl_pkg::div_stage_t  stage_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output obl_pkg::div_stage_t  stage_o
);
  import obl_pkg::*;

  logic       valid_q;
  div_stage_t stage_d, stage_q;

  assign ready_o = !valid_q || ready_i;

  // One restoring step per colour lane: try to take the shifted divisor away.
  always_comb begin
    logic [NumW-1:0] shift_w;
    logic            take;
    stage_d = stage_i;
    for (int l = 0; l < NumColour; l++) begin
      shift_w = NumW'(stage_i.dvs) << BitIdx;
      take    = (stage_i.rem[l] >= shift_w);
      if (take) stage_d.rem[l] = stage_i.rem[l] - shift_w;
      stage_d.quo[l][BitIdx] = take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== dv/alpha_over_blend_tb.sv =====
// Testbench for alpha_over_blend: Porter-Duff "over" compositing of one
// foreground RGBA8 pixel over one background pixel, alpha not premultiplied.
//
// Every pixel that the block accepts is run through composite_over(). That
// function is an exact integer predictor of the blend, and its result is
// queued in pending_pix. The checker compares each result transfer on the
// output, field by field, with the oldest queued pixel.
//
// Inputs are driven at the falling clock edge, and outputs are sampled at the
// rising edge. The sender and the receiver each idle at random. Most gaps are
// short, a few are long, and some stretches have no idling at all. One test
// holds the receiver off for a long count of cycles, so that the pipeline
// fills and back-pressures the sender. Another test makes the sender wait
// until every outstanding pixel has been checked.

module alpha_over_blend_tb;
  import obl_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 8;
  // The block holds a pixel only in its weighting stages and divider cells, so
  // the quiet cycles at the end are enough to expose any stray output transfer.
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned TimeoutCycles = 500_000;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned Opaque        = 255;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  obl_pix_in_if  pix_in ();
  obl_pix_out_if pix_out ();

  alpha_over_blend dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_in),
    .pix_o  (pix_out)
  );

  // Blended pixels that are still to come out, oldest first.
  pix_out_t pending_pix[$];

  int unsigned fail_count     = 0;
  int unsigned mismatch_count = 0;
  int unsigned pixels_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned transparent_px = 0;
  int unsigned opaque_px      = 0;

  // The test tasks set these idling controls; the receiver keeps rx_stall_left.
  bit          src_gaps_on    = 1'b1;
  bit          rx_stalls_on   = 1'b1;
  int unsigned rx_hold_cycles = 0;
  int unsigned rx_stall_left  = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One colour channel is a weighted mean of back and front. The weights sum
  // to the denominator, so the quotient never exceeds 255.
  function automatic logic [ChanW-1:0] weigh_channel(input int unsigned back_c,
                                                     input int unsigned front_c,
                                                     input int unsigned back_w,
                                                     input int unsigned front_w,
                                                     input int unsigned denom);
    return ChanW'((back_c * back_w + front_c * front_w) / denom);
  endfunction

  function automatic pix_out_t composite_over(input pix_in_t px);
    int unsigned fa;
    int unsigned back_w;
    int unsigned front_w;
    int unsigned denom;
    pix_out_t    res;
    fa = px.front_alpha;
    // A fully transparent foreground passes the background through untouched,
    // and that includes its alpha.
    if (fa == 0) begin
      res.out_red   = px.back_red;
      res.out_green = px.back_green;
      res.out_blue  = px.back_blue;
      res.out_alpha = px.back_alpha;
      return res;
    end
    back_w  = int'(px.back_alpha) * (Opaque - fa);
    front_w = Opaque * fa;
    denom   = back_w + front_w;
    res.out_red   = weigh_channel(px.back_red, px.front_red, back_w, front_w, denom);
    res.out_green = weigh_channel(px.back_green, px.front_green, back_w, front_w, denom);
    res.out_blue  = weigh_channel(px.back_blue, px.front_blue, back_w, front_w, denom);
    res.out_alpha = ChanW'(denom / Opaque);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // This returns the length of an idle gap. Most gaps are zero or very short,
  // and about one in ten is long; the longest are enough to empty the pipeline.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // The alphas are biased towards their extremes and towards the values next
  // to them, because that is where the arithmetic changes its character.
  function automatic logic [ChanW-1:0] pick_alpha();
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return ChanMax;
      end
      2: begin
        return 8'd1;
      end
      3: begin
        return ChanMax - 8'd1;
      end
      default: begin
        return ChanW'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    px             = pix_in_t'({$urandom(), $urandom()});
    px.back_alpha  = pick_alpha();
    px.front_alpha = pick_alpha();
    return px;
  endfunction

  // This task offers one pixel to the block and waits for its transfer. On
  // entry it waits for the next falling edge. If no gap is due, valid stays
  // high from one pixel to the next, so back-to-back transfers are possible.
  task automatic send_pixel(input pix_in_t px);
    int unsigned gap;
    gap = src_gaps_on ? idle_length() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      pix_in.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_in.valid = 1'b1;
    pix_in.data  = px;
    do begin
      @(posedge clk_i);
    end while (!pix_in.ready);
    pending_pix.push_back(composite_over(px));
    pixels_sent++;
    if (px.front_alpha == '0) begin
      transparent_px++;
    end else if (px.front_alpha == ChanMax) begin
      opaque_px++;
    end
  endtask

  // The sender goes quiet here until every queued pixel has been checked.
  task automatic wait_drained();
    @(negedge clk_i);
    pix_in.valid = 1'b0;
    while (pending_pix.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------------------

  // Apart from its initial value, ready is driven only from this process. A
  // hold-off requested by a test takes priority over the random stalls, and it
  // is counted down here, one cycle at a time.
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      pix_out.ready = 1'b0;
      rx_hold_cycles--;
    end else if (rx_stall_left > 0) begin
      pix_out.ready = 1'b0;
      rx_stall_left--;
    end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
      pix_out.ready = 1'b0;
      rx_stall_left = idle_length();
    end else begin
      pix_out.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [ChanW-1:0] want,
                             input logic [ChanW-1:0] got);
    if (got !== want) begin
      fail_count++;
      mismatch_count++;
      if (mismatch_count <= MaxReported) begin
        $display("mismatch on %s at %0t: expected %0d, got %0d", name, $realtime,
                 want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    pix_out_t want;
    pix_out_t got;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      got = pix_out.data;
      if (pending_pix.size() == 0) begin
        fail_count++;
        $display("unexpected output transfer at %0t: %h", $realtime, got);
      end else begin
        want = pending_pix.pop_front();
        check_field("out_red", want.out_red, got.out_red);
        check_field("out_green", want.out_green, got.out_green);
        check_field("out_blue", want.out_blue, got.out_blue);
        check_field("out_alpha", want.out_alpha, got.out_alpha);
        pixels_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // These are hand-picked pixels. They cover a transparent foreground, which
  // must return the background as it is, and an opaque foreground, which must
  // return the foreground with full alpha. They cover the smallest foreground
  // alpha over no background, where the divisor is at its least. They also
  // cover mid-range blends and alternating bit patterns.
  task automatic test_directed();
    send_pixel(pix_in_t'({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}));
    send_pixel(pix_in_t'({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}));
    send_pixel(pix_in_t'({8'd12, 8'd34, 8'd56, 8'd78, 8'hFF, 8'hFF, 8'hFF, 8'h00}));
    send_pixel(pix_in_t'({8'd200, 8'd100, 8'd50, 8'h00, 8'd9, 8'd8, 8'd7, 8'h00}));
    send_pixel(pix_in_t'({8'd10, 8'd20, 8'd30, 8'hFF, 8'd40, 8'd50, 8'd60, 8'hFF}));
    send_pixel(pix_in_t'({8'd10, 8'd20, 8'd30, 8'h00, 8'd40, 8'd50, 8'd60, 8'hFF}));
    send_pixel(pix_in_t'({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));
    send_pixel(pix_in_t'({8'hFF, 8'h80, 8'h01, 8'h00, 8'h01, 8'h80, 8'hFF, 8'h01}));
    send_pixel(pix_in_t'({8'hFF, 8'h80, 8'h01, 8'hFF, 8'h01, 8'h80, 8'hFF, 8'h01}));
    send_pixel(pix_in_t'({8'h00, 8'hFF, 8'h7F, 8'h01, 8'hFF, 8'h00, 8'h80, 8'h01}));
    send_pixel(pix_in_t'({8'h00, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFE}));
    send_pixel(pix_in_t'({8'h00, 8'hFF, 8'h7F, 8'h01, 8'hFF, 8'h00, 8'h80, 8'hFE}));
    send_pixel(pix_in_t'({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80}));
    send_pixel(pix_in_t'({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80}));
    send_pixel(pix_in_t'({8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80}));
    send_pixel(pix_in_t'({8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA}));
    send_pixel(pix_in_t'({8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55}));
    wait_drained();
  endtask

  // This is the bulk of the run. Within every block of 120 pixels, the first
  // 30 go through with no source gaps and no new receiver stalls, and the rest
  // see random gaps and stalls on both sides.
  task automatic test_random_stream();
    for (int i = 0; i < 720; i++) begin
      src_gaps_on  = (i % 120) >= 30;
      rx_stalls_on = (i % 120) >= 30;
      send_pixel(random_pixel());
    end
    src_gaps_on  = 1'b1;
    rx_stalls_on = 1'b1;
    wait_drained();
  endtask

  // The receiver is held off for a long stretch while the sender keeps
  // offering pixels. The stages fill up, and the input must stall without
  // losing or reordering anything.
  task automatic test_output_hold_off();
    src_gaps_on = 1'b0;
    @(posedge clk_i);
    rx_hold_cycles = HoldOffCycles;
    for (int i = 0; i < 48; i++) begin
      send_pixel(random_pixel());
    end
    src_gaps_on = 1'b1;
    wait_drained();
  endtask

  // This test runs two bursts. Between them, the sender waits until the
  // pipeline has emptied completely, so the second burst enters an idle block.
  task automatic test_drain_pause();
    for (int burst = 0; burst < 2; burst++) begin
      for (int i = 0; i < 40; i++) begin
        send_pixel(random_pixel());
      end
      wait_drained();
    end
  endtask

  // Both sides run at full rate, one transfer every clock once old stalls end.
  task automatic test_back_to_back();
    src_gaps_on  = 1'b0;
    rx_stalls_on = 1'b0;
    for (int i = 0; i < 90; i++) begin
      send_pixel(random_pixel());
    end
    src_gaps_on  = 1'b1;
    rx_stalls_on = 1'b1;
    wait_drained();
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_pix.size() != 0) begin
      fail_count++;
      $display("%0d blended pixels never came out", pending_pix.size());
    end
    $display("%0d pixels composited and checked, %0d with a clear and %0d with a solid foreground",
             pixels_checked, transparent_px, opaque_px);
    $display("%0d pixels sent; long output hold-off and full drain both exercised",
             pixels_sent);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  // Reset falls shortly after time zero, so the asynchronous reset sees a real
  // edge before the first rising clock edge.
  initial begin
    pix_in.valid  = 1'b0;
    pix_in.data   = '0;
    pix_out.ready = 1'b0;
    #1 rst_ni = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_stream();
    test_output_hold_off();
    test_drain_pause();
    test_back_to_back();
    finish_run();
  end

  // This is a backstop against a hung handshake. It is set far above the
  // length of the slowest legal run.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("TB_ERROR");
    $finish;
  end

endmodule
